@@ design/bir_pkg.sv @@
// ----------------------------------------------------------------------------
// bir_pkg
// Shared types and constants of the bilinear image resize unit.
// ----------------------------------------------------------------------------
package bir_pkg;

  // Default depth of the source pixel store.
  localparam int SOURCE_PIXELS = 65536;

  // Fixed-point layout of the source position.
  localparam int FRAC_BITS = 10;
  localparam int STEP_W    = 19;  // 9-bit size shifted by the fraction bits
  localparam int POS_W     = 31;  // 12-bit coordinate times a step
  localparam int WEIGHT_SHIFT = 12;

  localparam logic [9:0] FRAC_MAX = 10'd1023;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HEIGHT = 2'd3;
  localparam int CFG_DATA_W = 13;

  // Register reset values and the steps that follow from them.
  localparam logic [8:0]        SOURCE_SIZE_RST = 9'd256;
  localparam logic [12:0]       TARGET_SIZE_RST = 13'd256;
  localparam logic [STEP_W-1:0] STEP_RST        = 19'd1024;

  // Input item opcodes.
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [15:0] load_index;
    logic [23:0] load_rgb;
    logic [11:0] dest_x;
    logic [11:0] dest_y;
  } in_item_t;

  typedef struct packed {
    logic [23:0] sample_rgb;
    logic [11:0] sample_x;
    logic [11:0] sample_y;
  } out_item_t;

endpackage

@@ design/bir_step_div.sv @@
// ----------------------------------------------------------------------------
// bir_step_div
// Restoring divider that works out the horizontal and vertical steps
// (size << 10) / target, one quotient bit per cycle for both axes.
// ----------------------------------------------------------------------------
module bir_step_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [bir_pkg::STEP_W-1:0]       dividend_x,
  input  logic [12:0]                      divisor_x,
  input  logic [bir_pkg::STEP_W-1:0]       dividend_y,
  input  logic [12:0]                      divisor_y,
  output logic                             busy,
  output logic [bir_pkg::STEP_W-1:0]       step_x,
  output logic [bir_pkg::STEP_W-1:0]       step_y
);

  localparam int SW = bir_pkg::STEP_W;

  typedef enum logic [1:0] {
    DIV_IDLE = 2'b01,
    DIV_RUN  = 2'b10
  } div_state_t;

  div_state_t  state_r, state_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [SW-1:0] qx_r, qx_nxt, qy_r, qy_nxt;
  logic [12:0] rx_r, rx_nxt, ry_r, ry_nxt;
  logic [12:0] dx_r, dy_r;
  logic [SW-1:0] step_x_r, step_x_nxt, step_y_r, step_y_nxt;
  logic [13:0] trial_x, trial_y;

  // One restoring step per axis.
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    qx_nxt     = qx_r;
    qy_nxt     = qy_r;
    rx_nxt     = rx_r;
    ry_nxt     = ry_r;
    step_x_nxt = step_x_r;
    step_y_nxt = step_y_r;
    trial_x    = {rx_r, qx_r[SW-1]};
    trial_y    = {ry_r, qy_r[SW-1]};
    if (start) begin
      state_nxt = DIV_RUN;
      cnt_nxt   = 5'(SW);
      qx_nxt    = dividend_x;
      qy_nxt    = dividend_y;
      rx_nxt    = '0;
      ry_nxt    = '0;
    end else if (state_r == DIV_RUN) begin
      if (trial_x >= {1'b0, dx_r}) begin
        rx_nxt = 13'(trial_x - {1'b0, dx_r});
        qx_nxt = {qx_r[SW-2:0], 1'b1};
      end else begin
        rx_nxt = trial_x[12:0];
        qx_nxt = {qx_r[SW-2:0], 1'b0};
      end
      if (trial_y >= {1'b0, dy_r}) begin
        ry_nxt = 13'(trial_y - {1'b0, dy_r});
        qy_nxt = {qy_r[SW-2:0], 1'b1};
      end else begin
        ry_nxt = trial_y[12:0];
        qy_nxt = {qy_r[SW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        state_nxt  = DIV_IDLE;
        step_x_nxt = qx_nxt;
        step_y_nxt = qy_nxt;
      end
    end
  end

  // Control and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= DIV_IDLE;
      cnt_r    <= '0;
      step_x_r <= bir_pkg::STEP_RST;
      step_y_r <= bir_pkg::STEP_RST;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      step_x_r <= step_x_nxt;
      step_y_r <= step_y_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    qx_r <= qx_nxt;
    qy_r <= qy_nxt;
    rx_r <= rx_nxt;
    ry_r <= ry_nxt;
    if (start) begin
      dx_r <= divisor_x;
      dy_r <= divisor_y;
    end
  end

  assign busy   = (state_r == DIV_RUN);
  assign step_x = step_x_r;
  assign step_y = step_y_r;

endmodule

@@ design/bir_addr_mod.sv @@
// ----------------------------------------------------------------------------
// bir_addr_mod
// Three-stage reduction of a neighbor address modulo the store depth by a
// reciprocal multiply and one correcting subtract.
// ----------------------------------------------------------------------------
module bir_addr_mod #(
  parameter int SOURCE_PIXELS = bir_pkg::SOURCE_PIXELS,
  parameter int AW            = $clog2(SOURCE_PIXELS)
) (
  input  logic                       clk,
  input  logic [bir_pkg::POS_W-1:0]  addr_i,
  output logic [AW-1:0]              addr_o
);

  localparam int XW = bir_pkg::POS_W;
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / SOURCE_PIXELS);
  localparam logic [AW:0] MODN  = (AW+1)'(SOURCE_PIXELS);

  logic [XW+31:0]  prod;
  logic [XW-1:0]   quo_r;
  logic [XW-1:0]   x1_r;
  logic [2*AW+1:0] qn;
  logic [AW:0]     rem_r;
  logic [AW-1:0]   addr_r;

  // Estimated quotient, low by at most one.
  assign prod = {32'd0, addr_i} * {{XW{1'b0}}, RECIP};
  assign qn   = quo_r[AW:0] * MODN;

  always_ff @(posedge clk) begin
    quo_r <= prod[XW+31:32];
    x1_r  <= addr_i;
    // The true remainder lies below twice the depth, so low bits suffice.
    rem_r <= x1_r[AW:0] - qn[AW:0];
    if (rem_r >= MODN) begin
      addr_r <= AW'(rem_r - MODN);
    end else begin
      addr_r <= rem_r[AW-1:0];
    end
  end

  assign addr_o = addr_r;

endmodule

@@ design/bir_pixel_mem.sv @@
// ----------------------------------------------------------------------------
// bir_pixel_mem
// One copy of the source pixel store: one write port and one registered
// read port.
// ----------------------------------------------------------------------------
module bir_pixel_mem #(
  parameter int SOURCE_PIXELS = bir_pkg::SOURCE_PIXELS,
  parameter int AW            = $clog2(SOURCE_PIXELS)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [23:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [23:0]   rd_data
);

  logic [23:0] mem_r [SOURCE_PIXELS];
  logic [23:0] rd_data_r;

  // Synchronous write and read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ design/bilinear_image_resize_unit.sv @@
// ----------------------------------------------------------------------------
// bilinear_image_resize_unit
// Bilinear scaler: loads fill four copies of the source store, samples read
// the 2x2 neighbors from them and blend each channel.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while busy is low; every load writes all four store copies in
// the same pipeline stage where samples read them, so order is kept.
// After a configuration write, busy stays high while the step
// divider runs one quotient bit per cycle.
// Reset clears the pipeline and sets all sizes to 256; the store is not
// cleared. The receiver cannot stall, so results are never held back.
module bilinear_image_resize_unit #(
  parameter int SOURCE_PIXELS = bir_pkg::SOURCE_PIXELS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  bir_pkg::in_item_t                   in_item,
  output logic                                out_valid,
  output bir_pkg::out_item_t                  out_item,
  input  logic                                cfg_we,
  input  logic [bir_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bir_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int AW = $clog2(SOURCE_PIXELS);
  localparam int SW = bir_pkg::STEP_W;
  localparam int PW = bir_pkg::POS_W;
  localparam int FB = bir_pkg::FRAC_BITS;
  localparam int NS = 9;  // item stages before the output register

  typedef struct packed {
    logic [AW-1:0] waddr;
    logic [23:0]   rgb;
    logic [11:0]   dx;
    logic [11:0]   dy;
  } stage_t;

  // Configuration registers.
  logic [8:0]  src_w_r, src_h_r;
  logic [12:0] tgt_w_r, tgt_h_r;
  logic        kick_r;
  logic [8:0]  ow, oh;
  logic [12:0] tw, th;
  logic        div_busy;
  logic [SW-1:0] step_x, step_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= bir_pkg::SOURCE_SIZE_RST;
      src_h_r <= bir_pkg::SOURCE_SIZE_RST;
      tgt_w_r <= bir_pkg::TARGET_SIZE_RST;
      tgt_h_r <= bir_pkg::TARGET_SIZE_RST;
      kick_r  <= 1'b0;
    end else begin
      kick_r <= cfg_we;
      if (cfg_we) begin
        unique case (cfg_index)
          bir_pkg::CFG_SOURCE_WIDTH:  src_w_r <= cfg_data[8:0];
          bir_pkg::CFG_SOURCE_HEIGHT: src_h_r <= cfg_data[8:0];
          bir_pkg::CFG_TARGET_WIDTH:  tgt_w_r <= cfg_data;
          bir_pkg::CFG_TARGET_HEIGHT: tgt_h_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // A zero size acts as one.
  assign ow = (src_w_r == '0) ? 9'd1 : src_w_r;
  assign oh = (src_h_r == '0) ? 9'd1 : src_h_r;
  assign tw = (tgt_w_r == '0) ? 13'd1 : tgt_w_r;
  assign th = (tgt_h_r == '0) ? 13'd1 : tgt_h_r;

  bir_step_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (kick_r),
    .dividend_x ({ow, {FB{1'b0}}}),
    .divisor_x  (tw),
    .dividend_y ({oh, {FB{1'b0}}}),
    .divisor_y  (th),
    .busy       (div_busy),
    .step_x     (step_x),
    .step_y     (step_y)
  );

  assign busy = kick_r | div_busy;

  // Item pipeline control and payload.
  logic          accept;
  logic          idx_ok;
  logic [NS:1]   smp_r;
  logic [NS:1]   ld_r;
  stage_t        pay_r [1:NS];

  assign accept = start & ~busy;
  assign idx_ok = 32'(in_item.load_index) < 32'(SOURCE_PIXELS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_r <= '0;
      ld_r  <= '0;
    end else begin
      smp_r <= {smp_r[NS-1:1], accept & (in_item.opcode == bir_pkg::OP_SAMPLE)};
      ld_r  <= {ld_r[NS-1:1],
                accept & (in_item.opcode == bir_pkg::OP_LOAD) & idx_ok};
    end
  end

  always_ff @(posedge clk) begin
    pay_r[1] <= '{waddr: AW'(in_item.load_index), rgb: in_item.load_rgb,
                  dx: in_item.dest_x, dy: in_item.dest_y};
    for (int s = 2; s <= NS; s++) begin
      pay_r[s] <= pay_r[s-1];
    end
  end

  // Stage 2: source position.
  logic [PW-1:0] su_r, sv_r;
  always_ff @(posedge clk) begin
    su_r <= PW'(pay_r[1].dx * step_x);
    sv_r <= PW'(pay_r[1].dy * step_y);
  end

  // Stage 3: integer parts, fractions, edge fallback and row offset.
  logic [31:0]       reach_x, reach_y, lim_x, lim_y;
  logic [PW-FB-1:0]  col_r;
  logic [PW-2:0]     rowoff_r;
  logic              offx_r, offy_r;
  logic [9:0]        fu_r, fv_r;

  assign reach_x = 32'(su_r) + 32'(step_x);
  assign reach_y = 32'(sv_r) + 32'(step_y);
  assign lim_x   = 32'(ow - 9'd1) << FB;
  assign lim_y   = 32'(oh - 9'd1) << FB;

  always_ff @(posedge clk) begin
    col_r    <= su_r[PW-1:FB];
    rowoff_r <= (PW-1)'(sv_r[PW-1:FB] * ow);
    offx_r   <= !(reach_x > lim_x);
    offy_r   <= !(reach_y > lim_y);
    fu_r     <= su_r[FB-1:0];
    fv_r     <= sv_r[FB-1:0];
  end

  // Stage 4: neighbor addresses and weights.
  logic [PW-1:0] base, offy_v;
  logic [PW-1:0] addr_r [4];
  logic [19:0]   wp [4];
  logic [7:0]    wgt_r [4:8][4];

  assign base   = PW'(col_r) + PW'(rowoff_r);
  assign offy_v = offy_r ? PW'(ow) : '0;
  assign wp[0]  = (bir_pkg::FRAC_MAX - fu_r) * (bir_pkg::FRAC_MAX - fv_r);
  assign wp[1]  = fu_r * (bir_pkg::FRAC_MAX - fv_r);
  assign wp[2]  = (bir_pkg::FRAC_MAX - fu_r) * fv_r;
  assign wp[3]  = fu_r * fv_r;

  always_ff @(posedge clk) begin
    addr_r[0] <= base;
    addr_r[1] <= base + PW'(offx_r);
    addr_r[2] <= base + offy_v;
    addr_r[3] <= base + offy_v + PW'(offx_r);
    for (int k = 0; k < 4; k++) begin
      wgt_r[4][k] <= wp[k][bir_pkg::WEIGHT_SHIFT+7:bir_pkg::WEIGHT_SHIFT];
    end
    for (int s = 5; s <= 8; s++) begin
      wgt_r[s] <= wgt_r[s-1];
    end
  end

  // Stages 5 to 7: address reduction; stage 7 reads or writes the store copies.
  logic [AW-1:0] raddr [4];
  logic [23:0]   pix [4];

  for (genvar g = 0; g < 4; g++) begin : g_nb
    bir_addr_mod #(
      .SOURCE_PIXELS (SOURCE_PIXELS),
      .AW            (AW)
    ) u_mod (
      .clk    (clk),
      .addr_i (addr_r[g]),
      .addr_o (raddr[g])
    );

    bir_pixel_mem #(
      .SOURCE_PIXELS (SOURCE_PIXELS),
      .AW            (AW)
    ) u_mem (
      .clk     (clk),
      .wr_en   (ld_r[7]),
      .wr_addr (pay_r[7].waddr),
      .wr_data (pay_r[7].rgb),
      .rd_en   (smp_r[7]),
      .rd_addr (raddr[g]),
      .rd_data (pix[g])
    );
  end

  // Stage 9: channel times weight products.
  logic [15:0] prod_r [3][4];
  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < 4; k++) begin
        prod_r[c][k] <= pix[k][8*c +: 8] * wgt_r[8][k];
      end
    end
  end

  // Output register: sum and scale each channel.
  logic [17:0]        acc [3];
  logic               out_valid_r;
  bir_pkg::out_item_t out_item_r;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc[c] = 18'(prod_r[c][0]) + 18'(prod_r[c][1]) +
               18'(prod_r[c][2]) + 18'(prod_r[c][3]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= smp_r[NS];
    end
  end

  always_ff @(posedge clk) begin
    out_item_r.sample_rgb <= {acc[2][15:8], acc[1][15:8], acc[0][15:8]};
    out_item_r.sample_x   <= pay_r[NS].dx;
    out_item_r.sample_y   <= pay_r[NS].dy;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Assertions.
  a_cfg_busy : assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> busy)
    else $error("busy not raised after a configuration write");

  a_out_origin : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && in_item.opcode == bir_pkg::OP_SAMPLE, 10))
    else $error("result without a sample accepted ten cycles earlier");

  a_step_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (!busy && $past(!busy)) |-> ($stable(step_x) && $stable(step_y)))
    else $error("step changed while the block was not busy");

  a_rw_excl : assert property (@(posedge clk) disable iff (!rst_n)
    !(ld_r[7] && smp_r[7]))
    else $error("store read and write in the same stage");

endmodule
